// ===== hdl/drip_rate_meter_core_macros.svh =====
// Assertion macros shared by the drip rate meter checker
`ifndef DRIP_RATE_METER_CORE_MACROS_SVH
`define DRIP_RATE_METER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, idle during reset
`define DRM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("drip rate meter check failed");

// Next-cycle implication, sampled on clk, idle during reset
`define DRM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("drip rate meter check failed");

`endif

// ===== hdl/drm_pkg.sv =====
// Shared constants, command and status types of the drip rate meter
package drm_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_DEB   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DROPS_UNIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VOL   = 2'd3;

    // register reset values
    localparam logic [15:0] WINDOW_RST   = 16'd3000;
    localparam logic [9:0]  IDLE_DEB_RST = 10'd100;
    localparam logic [7:0]  DPU_RST      = 8'd13;
    localparam logic [23:0] INIT_VOL_RST = 24'd0;

    // 60000 ms per minute in Q8, and 15000 ms in Q8
    localparam logic [23:0] RATE_SCALE = 24'd15360000;
    localparam logic [21:0] DEB_SCALE  = 22'd3840000;
    localparam logic [27:0] ROUND_ADD  = 28'd5;

    // ceil(2^31 / 10): x / 10 is (x * RECIP10) >> 31 for any x below 2^28
    localparam logic [27:0] RECIP10 = 28'd214748365;

    localparam logic [23:0] MAX24 = 24'hFFFFFF;

    // shared divider
    localparam int DIV_NUM_W = 40;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_CNT_W = 6;

    // quotient widths of each division
    localparam logic [DIV_CNT_W-1:0] N_RAW    = 6'd40;
    localparam logic [DIV_CNT_W-1:0] N_USED   = 6'd32;
    localparam logic [DIV_CNT_W-1:0] N_DEB    = 6'd22;

    // divider operations
    localparam logic [1:0] OP_RAW    = 2'd0;
    localparam logic [1:0] OP_USED   = 2'd1;
    localparam logic [1:0] OP_DEB    = 2'd2;

    typedef struct packed {
        logic       load_sample;
        logic       update;
        logic       mul_raw;
        logic       sum_smooth;
        logic       smooth_load;
        logic       div_start;
        logic [1:0] div_op;
        logic       load_out;
    } drm_cmd_t;

    typedef struct packed {
        logic window_end;
        logic div_done;
    } drm_status_t;

endpackage

// ===== hdl/drm_if.sv =====
// Sample and result channel interfaces of the drip rate meter

// Sensor sample channel
interface drm_sample_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_time_ms;
    logic        sensor_level;

    modport source (output valid, output sample_time_ms, output sensor_level, input ready);
    modport sink   (input valid, input sample_time_ms, input sensor_level, output ready);
    modport mon    (input valid, input sample_time_ms, input sensor_level, input ready);
endinterface

// Rate result channel
interface drm_result_if;
    logic               valid;
    logic               ready;
    logic [23:0]        drip_rate_q8;
    logic [23:0]        drop_total;
    logic [23:0]        volume_used_q8;
    logic signed [24:0] volume_left_q8;

    modport source (output valid, output drip_rate_q8, output drop_total,
                    output volume_used_q8, output volume_left_q8, input ready);
    modport sink   (input valid, input drip_rate_q8, input drop_total,
                    input volume_used_q8, input volume_left_q8, output ready);
    modport mon    (input valid, input drip_rate_q8, input drop_total,
                    input volume_used_q8, input volume_left_q8, input ready);
endinterface

// ===== hdl/drm_div.sv =====
// Restoring divider, one quotient bit per cycle, dividend left aligned
module drm_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [drm_pkg::DIV_NUM_W-1:0]  dividend,
    input  logic [drm_pkg::DIV_DEN_W-1:0]  divisor,
    input  logic [drm_pkg::DIV_CNT_W-1:0]  nbits,
    output logic                           done,
    output logic [drm_pkg::DIV_NUM_W-1:0]  quotient
);
    import drm_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] q_reg, q_next;
    logic [DIV_DEN_W-1:0] r_reg, r_next;
    logic [DIV_DEN_W-1:0] d_reg, d_next;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;

    // one compare-subtract step
    assign trial = {r_reg, q_reg[DIV_NUM_W-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign ge    = (trial >= {1'b0, d_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = nbits;
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[DIV_NUM_W-2:0], ge};
            r_next   = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operands need no reset
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== hdl/drm_ctrl.sv =====
// Sequencer of the drip rate meter: handshakes and divider schedule
module drm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  drm_pkg::drm_status_t status,
    output drm_pkg::drm_cmd_t    cmd
);
    import drm_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_UPD      = 4'd1;
    localparam logic [3:0] S_MUL      = 4'd2;
    localparam logic [3:0] S_RAW_GO   = 4'd3;
    localparam logic [3:0] S_RAW_WAIT = 4'd4;
    localparam logic [3:0] S_SUM      = 4'd5;
    localparam logic [3:0] S_SMOOTH   = 4'd6;
    localparam logic [3:0] S_USE_GO   = 4'd7;
    localparam logic [3:0] S_USE_WAIT = 4'd8;
    localparam logic [3:0] S_DEB_GO   = 4'd9;
    localparam logic [3:0] S_DEB_WAIT = 4'd10;
    localparam logic [3:0] S_EMIT     = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        // result slot drains on a beat
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_sample = 1'b1;
                    state_next      = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = status.window_end ? S_MUL : S_IDLE;
            end
            S_MUL:
            begin
                cmd.mul_raw = 1'b1;
                state_next  = S_RAW_GO;
            end
            S_RAW_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = OP_RAW;
                state_next    = S_RAW_WAIT;
            end
            S_RAW_WAIT:
            begin
                cmd.div_op = OP_RAW;
                if (status.div_done)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.sum_smooth = 1'b1;
                state_next     = S_SMOOTH;
            end
            S_SMOOTH:
            begin
                // divide by ten through the reciprocal product
                cmd.smooth_load = 1'b1;
                state_next      = S_USE_GO;
            end
            S_USE_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = OP_USED;
                state_next    = S_USE_WAIT;
            end
            S_USE_WAIT:
            begin
                cmd.div_op = OP_USED;
                if (status.div_done)
                begin
                    state_next = S_DEB_GO;
                end
            end
            S_DEB_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = OP_DEB;
                state_next    = S_DEB_WAIT;
            end
            S_DEB_WAIT:
            begin
                cmd.div_op = OP_DEB;
                if (status.div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // wait for a free output slot
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== hdl/drm_dp.sv =====
// Datapath of the drip rate meter: registers, drop tracking, rate math
module drm_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [31:0]                        sample_time_ms,
    input  logic                               sensor_level,
    input  logic                               cfg_we,
    input  logic [drm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [drm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  drm_pkg::drm_cmd_t                  cmd,
    output drm_pkg::drm_status_t               status,
    output logic [23:0]                        drip_rate_q8,
    output logic [23:0]                        drop_total,
    output logic [23:0]                        volume_used_q8,
    output logic signed [24:0]                 volume_left_q8
);
    import drm_pkg::*;

    // configuration
    logic [15:0] window_ms_reg, window_ms_next;
    logic [9:0]  idle_deb_reg, idle_deb_next;
    logic [7:0]  dpu_reg, dpu_next;
    logic [23:0] init_vol_reg, init_vol_next;

    // tracking state
    logic        prev_level_reg, prev_level_next;
    logic [31:0] last_accept_reg, last_accept_next;
    logic [31:0] last_drop_reg, last_drop_next;
    logic [31:0] win_start_reg, win_start_next;
    logic [15:0] win_drops_reg, win_drops_next;
    logic [31:0] win_sum_reg, win_sum_next;
    logic [23:0] smoothed_reg, smoothed_next;
    logic [23:0] drops_seen_reg, drops_seen_next;
    logic [21:0] deb_reg, deb_next;

    // work registers
    logic [31:0]          t_reg;
    logic                 lvl_reg;
    logic [39:0]          num_reg;
    logic [23:0]          raw_reg;
    logic [27:0]          sum_reg;
    logic [23:0]          used_reg;
    logic [23:0]          rate_out_reg;
    logic [23:0]          total_out_reg;
    logic [23:0]          used_out_reg;
    logic signed [24:0]   left_out_reg;

    logic [31:0]          delta_acc;
    logic [31:0]          delta_drop;
    logic [31:0]          delta_win;
    logic [21:0]          deb_cur;
    logic                 is_drop;
    logic [32:0]          sum_ext;
    logic [7:0]           dpu_eff;
    logic [27:0]          old_x7;
    logic [27:0]          raw_x3;
    logic [55:0]          smooth_prod;

    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_CNT_W-1:0] div_n;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_q;

    // drop detection on the latched sample
    assign delta_acc  = t_reg - last_accept_reg;
    assign delta_drop = t_reg - last_drop_reg;
    assign delta_win  = t_reg - win_start_reg;
    assign deb_cur    = (smoothed_reg == '0) ? {12'd0, idle_deb_reg} : deb_reg;
    assign is_drop    = lvl_reg && !prev_level_reg && (delta_acc > {10'd0, deb_cur});
    assign sum_ext    = {1'b0, win_sum_reg} + {1'b0, delta_drop};
    assign dpu_eff    = (dpu_reg == '0) ? 8'd1 : dpu_reg;

    assign status.window_end = (delta_win >= {16'd0, window_ms_reg});
    assign status.div_done   = div_done;

    // blended sum divided by ten, quotient in bits 54:31
    assign smooth_prod = 56'(sum_reg) * 56'(RECIP10);

    // divider operand select
    always_comb
    begin
        case (cmd.div_op)
            OP_RAW:
            begin
                div_num = num_reg;
                div_den = win_sum_reg;
                div_n   = N_RAW;
            end
            OP_USED:
            begin
                div_num = {drops_seen_reg, 16'd0};
                div_den = {24'd0, dpu_eff};
                div_n   = N_USED;
            end
            OP_DEB:
            begin
                div_num = {DEB_SCALE, 18'd0};
                div_den = {8'd0, smoothed_reg};
                div_n   = N_DEB;
            end
            default:
            begin
                div_num = num_reg;
                div_den = win_sum_reg;
                div_n   = N_RAW;
            end
        endcase
    end

    drm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .nbits    (div_n),
        .done     (div_done),
        .quotient (div_q)
    );

    // next state of configuration and tracking registers
    always_comb
    begin
        window_ms_next   = window_ms_reg;
        idle_deb_next    = idle_deb_reg;
        dpu_next         = dpu_reg;
        init_vol_next    = init_vol_reg;
        prev_level_next  = prev_level_reg;
        last_accept_next = last_accept_reg;
        last_drop_next   = last_drop_reg;
        win_start_next   = win_start_reg;
        win_drops_next   = win_drops_reg;
        win_sum_next     = win_sum_reg;
        smoothed_next    = smoothed_reg;
        drops_seen_next  = drops_seen_reg;
        deb_next         = deb_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW:     window_ms_next = cfg_data[15:0];
                CFG_IDLE_DEB:   idle_deb_next  = cfg_data[9:0];
                CFG_DROPS_UNIT: dpu_next       = cfg_data[7:0];
                CFG_INIT_VOL:   init_vol_next  = cfg_data[23:0];
                default:        window_ms_next = window_ms_reg;
            endcase
        end

        // edge and drop bookkeeping
        if (cmd.update)
        begin
            prev_level_next = lvl_reg;
            if (is_drop)
            begin
                last_accept_next = t_reg;
                last_drop_next   = t_reg;
                win_sum_next     = sum_ext[32] ? 32'hFFFFFFFF : sum_ext[31:0];
                if (win_drops_reg != 16'hFFFF)
                begin
                    win_drops_next = win_drops_reg + 16'd1;
                end
                if (drops_seen_reg != MAX24)
                begin
                    drops_seen_next = drops_seen_reg + 24'd1;
                end
            end
        end

        // window restart once the raw rate is taken
        if (cmd.sum_smooth)
        begin
            win_sum_next   = '0;
            win_drops_next = '0;
            win_start_next = t_reg;
        end

        // new smoothed rate
        if (cmd.smooth_load)
        begin
            smoothed_next = smooth_prod[54:31];
        end

        if (div_done)
        begin
            case (cmd.div_op)
                OP_DEB:  deb_next = div_q[21:0];
                default: deb_next = deb_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ms_reg   <= WINDOW_RST;
            idle_deb_reg    <= IDLE_DEB_RST;
            dpu_reg         <= DPU_RST;
            init_vol_reg    <= INIT_VOL_RST;
            prev_level_reg  <= 1'b0;
            last_accept_reg <= '0;
            last_drop_reg   <= '0;
            win_start_reg   <= '0;
            win_drops_reg   <= '0;
            win_sum_reg     <= '0;
            smoothed_reg    <= '0;
            drops_seen_reg  <= '0;
            deb_reg         <= '0;
        end
        else
        begin
            window_ms_reg   <= window_ms_next;
            idle_deb_reg    <= idle_deb_next;
            dpu_reg         <= dpu_next;
            init_vol_reg    <= init_vol_next;
            prev_level_reg  <= prev_level_next;
            last_accept_reg <= last_accept_next;
            last_drop_reg   <= last_drop_next;
            win_start_reg   <= win_start_next;
            win_drops_reg   <= win_drops_next;
            win_sum_reg     <= win_sum_next;
            smoothed_reg    <= smoothed_next;
            drops_seen_reg  <= drops_seen_next;
            deb_reg         <= deb_next;
        end
    end

    // 7 * old + 3 * raw, by shifts
    assign old_x7 = ({4'd0, smoothed_reg} << 3) - {4'd0, smoothed_reg};
    assign raw_x3 = ({4'd0, raw_reg} << 1) + {4'd0, raw_reg};

    // work and result registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            t_reg   <= sample_time_ms;
            lvl_reg <= sensor_level;
        end
        if (cmd.mul_raw)
        begin
            num_reg <= {24'd0, win_drops_reg} * {16'd0, RATE_SCALE};
        end
        if (cmd.sum_smooth)
        begin
            sum_reg <= old_x7 + raw_x3 + ROUND_ADD;
        end
        if (div_done && (cmd.div_op == OP_RAW))
        begin
            if ((win_drops_reg == '0) || (win_sum_reg == '0))
            begin
                raw_reg <= '0;
            end
            else
            begin
                raw_reg <= (div_q[39:24] != '0) ? MAX24 : div_q[23:0];
            end
        end
        if (div_done && (cmd.div_op == OP_USED))
        begin
            used_reg <= (div_q[39:24] != '0) ? MAX24 : div_q[23:0];
        end
        if (cmd.load_out)
        begin
            rate_out_reg  <= smoothed_reg;
            total_out_reg <= drops_seen_reg;
            used_out_reg  <= used_reg;
            left_out_reg  <= $signed({1'b0, init_vol_reg}) - $signed({1'b0, used_reg});
        end
    end

    assign drip_rate_q8   = rate_out_reg;
    assign drop_total     = total_out_reg;
    assign volume_used_q8 = used_out_reg;
    assign volume_left_q8 = left_out_reg;

endmodule

// ===== hdl/drip_rate_meter_core.sv =====
// Drip rate meter: drop counting, windowed rate with smoothing, volume
//
// Channels: "sample" takes one timestamped sensor sample per beat
// (sample_time_ms, sensor_level); "result" gives one beat at the end of
// each measurement window (smoothed rate, drop total, volume used and
// left). Registers are written through cfg_we / cfg_index / cfg_data;
// the user must write them only while the block is idle, and the block
// itself does not enforce this. A sample that does not close a window
// passes through the load and update states and yields no beat. A sample
// that closes a window runs three divisions of 40, 32 and 22 steps on
// the single shared bit-serial divider plus a divide by ten through a
// reciprocal multiply.
// Only one sample is worked on at a time; sample.ready is high while idle.
// A finished result sits in the output register, so the next sample is
// taken while the receiver stalls; if a second result is ready before the
// first is taken, the block waits for the slot to free.
// Reset (rst_n low, asynchronous) clears all counters and the smoothed
// rate and loads the register defaults: 3000 ms window, 100 ms idle
// debounce, 13 drops per unit, zero initial volume.
module drip_rate_meter_core (
    input  logic                           clk,
    input  logic                           rst_n,
    drm_sample_if.sink                     sample,
    drm_result_if.source                   result,
    input  logic                           cfg_we,
    input  logic [drm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [drm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import drm_pkg::*;

    drm_cmd_t    cmd;
    drm_status_t status;

    drm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    drm_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_time_ms (sample.sample_time_ms),
        .sensor_level   (sample.sensor_level),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .status         (status),
        .drip_rate_q8   (result.drip_rate_q8),
        .drop_total     (result.drop_total),
        .volume_used_q8 (result.volume_used_q8),
        .volume_left_q8 (result.volume_left_q8)
    );

endmodule

// ===== hdl/drm_checker.sv =====
// Port-level checks of the drip rate meter and their binding
`include "drip_rate_meter_core_macros.svh"

module drm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [23:0]        drip_rate_q8,
    input logic [23:0]        drop_total,
    input logic [23:0]        volume_used_q8,
    input logic signed [24:0] volume_left_q8
);
    logic [31:0] used_w;
    logic [31:0] cap_w;
    logic [96:0] payload_w;
    logic        in_beat;
    logic        out_stall;

    assign used_w    = {8'd0, volume_used_q8};
    assign cap_w     = {drop_total, 8'd0};
    assign payload_w = {drip_rate_q8, drop_total, volume_used_q8, volume_left_q8};
    assign in_beat   = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;

    // a sample keeps the block busy in the cycle after it is taken
    `DRM_ASSERT_NXT(a_busy_after_beat, in_beat, !in_ready)

    // at least one drop per unit, so volume never exceeds drops in Q8
    `DRM_ASSERT_IMP(a_used_bound, out_valid, used_w <= cap_w)

    // a stalled result stays offered
    `DRM_ASSERT_NXT(a_valid_holds, out_stall, out_valid)

    // a stalled result keeps its payload
    `DRM_ASSERT_NXT(a_payload_holds, out_stall, $stable(payload_w))

endmodule

bind drip_rate_meter_core drm_checker u_drm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (sample.valid),
    .in_ready       (sample.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .drip_rate_q8   (result.drip_rate_q8),
    .drop_total     (result.drop_total),
    .volume_used_q8 (result.volume_used_q8),
    .volume_left_q8 (result.volume_left_q8)
);
